// ===== hw/rtl/scd_pkg.sv =====
// Package for the spike coincidence detector: codes, types and the decay table function.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

    localparam int NUM_CHANNELS_DEF    = 4;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int TIME_W      = 32;
    localparam int CHANNEL_W   = 2;
    localparam int WEIGHT_W    = 16;
    localparam int THRESH_W    = 18;
    localparam int RATE_W      = 16;
    localparam int FACTOR_W    = 16;
    localparam int INDEX_SHIFT = 12;
    localparam int MUL_A_W     = 33;
    localparam int MUL_B_W     = 17;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // exp(-1/16) in Q0.32
    localparam logic [63:0] DECAY_STEP = 64'd4034748383;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRACTORY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_RATE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_0   = 3'd3;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 18'sd256;
    localparam logic [TIME_W-1:0]   REFRACTORY_RST = 32'd0;
    localparam logic [RATE_W-1:0]   DECAY_RATE_RST = 16'd6554;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = 16'sd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_DT,
        ST_LOOKUP,
        ST_MUL_W,
        ST_DECIDE
    } state_t;

    typedef enum logic {
        MUL_DT,
        MUL_WEIGHT
    } mul_sel_t;

    typedef struct packed {
        logic     ready;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     rom_en;
        logic     commit;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic drop;
        logic carry_valid;
        logic fire;
        logic out_free;
    } sts_t;

    // Entry k of the decay table, by the integer recurrence p(k+1) = p(k) * step >> 32.
    function automatic logic [FACTOR_W-1:0] exp_entry(input int k);
        logic [63:0] p;
        logic [63:0] e;
        p = 64'h0000_0000_FFFF_FFFF;
        for (int i = 0; i < k; i++) begin
            p = (p * DECAY_STEP) >> 32;
        end
        e = (p + 64'd32768) >> 16;
        if (e > 64'd65535) begin
            e = 64'd65535;
        end
        return e[FACTOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spike_coincidence_detector.sv =====
// Top level of the spike coincidence detector: ports, registers and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Leaky integrate-and-fire neuron that carries one previous subthreshold spike.
// Input channel s_*: one item is a spike (s_spike_time, s_channel), times nondecreasing.
// Result channel m_*: zero or one item per spike, m_fire_time equal to the spike time.
// Config channel cfg_*: index 0 threshold, 1 refractory_ticks, 2 decay_rate,
// 3 onwards one weight per channel; other indexes are ignored. cfg_ready is always
// high; write only while no spike is in flight.
// Timing: s_ready is high only while the sequencer is idle. A dropped spike ends
// after the check step, a spike with nothing carried goes from check to decide, and
// a spike with a carried one steps through check, dt multiply, table read, weight
// multiply and decide, a sequence set by the one shared multiplier and the registered
// table read. A result appears on m_* the cycle after the decide step.
// Stall: a result waits in the output register; the next spike is still taken and
// worked on, and only its own decide step holds if it fires before the earlier
// result has gone.
// Reset (aresetn low, synchronous): configuration registers return to their defaults,
// nothing is carried, the neuron has never fired and no result is pending.
module spike_coincidence_detector #(
    parameter int NUM_CHANNELS    = scd_pkg::NUM_CHANNELS_DEF,
    parameter int EXP_TABLE_DEPTH = scd_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [scd_pkg::TIME_W-1:0]        s_spike_time,
    input  wire logic [scd_pkg::CHANNEL_W-1:0]     s_channel,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [scd_pkg::TIME_W-1:0]        m_fire_time,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [scd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import scd_pkg::*;

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

    // configuration
    logic signed [THRESH_W-1:0] threshold_reg;
    logic [TIME_W-1:0]          refractory_reg;
    logic [RATE_W-1:0]          decay_rate_reg;
    logic signed [WEIGHT_W-1:0] weight_reg [NUM_CHANNELS];

    // neuron state
    logic [TIME_W-1:0]          carry_time_reg;
    logic signed [WEIGHT_W-1:0] carry_weight_reg;
    logic                       carry_valid_reg;
    logic                       fire_valid_reg;
    logic [TIME_W-1:0]          last_fire_reg;

    // item in flight and result
    logic [TIME_W-1:0]          time_reg;
    logic [CHANNEL_W-1:0]       channel_reg;
    logic [TIME_W-1:0]          fire_time_reg;
    logic                       out_valid_reg;

    ctl_t ctl;
    sts_t sts;

    logic signed [WEIGHT_W-1:0] weight_sel;
    logic [TIME_W-1:0]          dt_fire;
    logic [TIME_W-1:0]          dt_carry;
    logic                       chan_bad;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod;
    logic [MUL_P_W-1:0]         prod_u;
    logic                       idx_in_range;
    logic [FACTOR_W-1:0]        factor;
    logic signed [THRESH_W-1:0] contrib;
    logic signed [THRESH_W-1:0] potential;
    logic                       fire;
    logic                       accept;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Select the weight of the spike's channel; an unused channel reads zero.
    always_comb begin
        weight_sel = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (channel_reg == CHANNEL_W'(i)) begin
                weight_sel = weight_reg[i];
            end
        end
    end

    assign chan_bad = {1'b0, channel_reg} >= (CHANNEL_W + 1)'(NUM_CHANNELS);
    assign dt_fire  = time_reg - last_fire_reg;
    assign dt_carry = time_reg - carry_time_reg;

    // Feed the shared multiplier: dt times decay rate first, then weight times factor.
    always_comb begin
        if (ctl.mul_sel == MUL_DT) begin
            mul_a = {1'b0, dt_carry};
            mul_b = {1'b0, decay_rate_reg};
        end else begin
            mul_a = MUL_A_W'(carry_weight_reg);
            mul_b = {1'b0, factor};
        end
    end

    scd_mul u_mul (
        .aclk (aclk),
        .en   (ctl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Table index is (dt * rate) >> 12; anything past the table decays to zero.
    assign prod_u       = prod;
    assign idx_in_range = prod_u[MUL_P_W-1:INDEX_SHIFT]
                          < (MUL_P_W - INDEX_SHIFT)'(EXP_TABLE_DEPTH);

    scd_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_rom (
        .aclk     (aclk),
        .en       (ctl.rom_en),
        .in_range (idx_in_range),
        .addr     (prod_u[INDEX_SHIFT+IDX_W-1:INDEX_SHIFT]),
        .factor   (factor)
    );

    // Floor of the product over 2^16, taken as an arithmetic shift.
    assign contrib   = carry_valid_reg ? prod[THRESH_W+15:16] : '0;
    assign potential = THRESH_W'(weight_sel) + contrib;
    assign fire      = potential >= threshold_reg;

    assign sts = '{
        in_valid:    s_valid,
        drop:        chan_bad || (fire_valid_reg && (dt_fire <= refractory_reg)),
        carry_valid: carry_valid_reg,
        fire:        fire,
        out_free:    !out_valid_reg || m_ready
    };

    scd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .ctl     (ctl)
    );

    assign s_ready = ctl.ready;

    // Hold the spike for the whole sequence.
    always_ff @(posedge aclk) begin
        if (accept) begin
            time_reg    <= s_spike_time;
            channel_reg <= s_channel;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RST;
            refractory_reg <= REFRACTORY_RST;
            decay_rate_reg <= DECAY_RATE_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                weight_reg[i] <= WEIGHT_RST;
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_THRESHOLD) begin
                threshold_reg <= cfg_data[THRESH_W-1:0];
            end
            if (cfg_index == REG_REFRACTORY) begin
                refractory_reg <= cfg_data[TIME_W-1:0];
            end
            if (cfg_index == REG_DECAY_RATE) begin
                decay_rate_reg <= cfg_data[RATE_W-1:0];
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (cfg_index == REG_WEIGHT_0 + CFG_INDEX_W'(i)) begin
                    weight_reg[i] <= cfg_data[WEIGHT_W-1:0];
                end
            end
        end
    end

    // Commit the decision: fire and clear the carry, or carry this spike forward.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_time_reg   <= '0;
            carry_weight_reg <= '0;
            carry_valid_reg  <= 1'b0;
            fire_valid_reg   <= 1'b0;
            last_fire_reg    <= '0;
        end else if (ctl.commit) begin
            if (fire) begin
                fire_valid_reg  <= 1'b1;
                last_fire_reg   <= time_reg;
                carry_valid_reg <= 1'b0;
            end else begin
                carry_time_reg   <= time_reg;
                carry_weight_reg <= weight_sel;
                carry_valid_reg  <= 1'b1;
            end
        end
    end

    // Output register: load on a firing commit, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.commit && fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit && fire) begin
            fire_time_reg <= time_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_fire_time = fire_time_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken while an item is still in flight");

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctl.commit && fire))
        else $error("result appeared without a firing commit");

    a_fire_clears_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.commit && fire) |=> (!carry_valid_reg && fire_valid_reg && m_valid))
        else $error("firing did not clear the carried spike");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.commit && fire) |-> (!out_valid_reg || m_ready))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/scd_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module scd_mul (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [scd_pkg::MUL_A_W-1:0]  a,
    input  wire logic signed [scd_pkg::MUL_B_W-1:0]  b,
    output logic signed      [scd_pkg::MUL_P_W-1:0]  prod
);
    import scd_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scd_exp_rom.sv =====
// Decay factor table with registered read; out-of-range lookups give zero.
`timescale 1ns / 1ps
`default_nettype none

module scd_exp_rom #(
    parameter int DEPTH = scd_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic                          in_range,
    input  wire logic [$clog2(DEPTH)-1:0]      addr,
    output logic      [scd_pkg::FACTOR_W-1:0]  factor
);
    import scd_pkg::*;

    logic [FACTOR_W-1:0] decay_lut [DEPTH];
    logic [FACTOR_W-1:0] factor_reg;

    for (genvar g = 0; g < DEPTH; g++) begin : g_lut
        assign decay_lut[g] = exp_entry(g);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            factor_reg <= in_range ? decay_lut[addr] : '0;
        end
    end

    assign factor = factor_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scd_ctrl.sv =====
// Steps one spike: check, then drop, or decide after mul, lookup, mul if carrying.
`timescale 1ns / 1ps
`default_nettype none

module scd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire scd_pkg::sts_t sts,
    output scd_pkg::ctl_t      ctl
);
    import scd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sts.in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.drop) begin
                    state_next = ST_IDLE;
                end else if (sts.carry_valid) begin
                    state_next = ST_MUL_DT;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_MUL_DT: state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_MUL_W;
            ST_MUL_W:  state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (!sts.fire || sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '{ready: 1'b0, mul_en: 1'b0, mul_sel: MUL_DT, rom_en: 1'b0, commit: 1'b0};
        case (state_reg)
            ST_IDLE:   ctl.ready = 1'b1;
            ST_CHECK:  ctl.ready = 1'b0;
            ST_MUL_DT: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_DT;
            end
            ST_LOOKUP: ctl.rom_en = 1'b1;
            ST_MUL_W:  begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_WEIGHT;
            end
            ST_DECIDE: ctl.commit = !sts.fire || sts.out_free;
            default:   ctl.ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/tb_spike_coincidence_detector.sv =====
// Self-checking testbench for the spike coincidence detector: directed and random spike trains.
`timescale 1ns / 1ps

module tb_spike_coincidence_detector;
    import scd_pkg::*;

    localparam int NUM_CH           = 4;
    localparam int LUT_DEPTH        = 256;
    localparam int LUT_SHIFT        = 12;
    // exp(-1/16) in Q0.32, one step of the decay table
    localparam logic [63:0] EXP_STEP = 64'd4034748383;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_1 = REG_WEIGHT_0 + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_2 = REG_WEIGHT_0 + 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_3 = REG_WEIGHT_0 + 3'd3;
    // beyond the register list: writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE    = 3'd7;

    localparam int RAND_PHASES      = 22;
    localparam int SPIKES_PER_PHASE = 50;
    localparam int SETTLE_CYCLES    = 16;
    localparam int CYCLE_LIMIT      = 800000;
    localparam int REPORT_LIMIT     = 10;

    // Predicts the fire times of accepted spikes and checks them in order.
    class fire_scoreboard;
        logic signed [THRESH_W-1:0] threshold;
        logic [TIME_W-1:0]          refractory;
        logic [RATE_W-1:0]          decay_rate;
        logic signed [WEIGHT_W-1:0] weight [NUM_CH];
        logic [TIME_W-1:0]          carry_time;
        logic signed [WEIGHT_W-1:0] carry_weight;
        logic                       carry_valid;
        logic                       has_fired;
        logic [TIME_W-1:0]          last_fire;
        logic [FACTOR_W-1:0]        decay_lut [LUT_DEPTH];
        logic [TIME_W-1:0]          expected_fires [$];
        int                         failures;

        function new();
            logic [63:0] p;
            logic [63:0] e;
            p = 64'h0000_0000_FFFF_FFFF;
            for (int k = 0; k < LUT_DEPTH; k++) begin
                e = (p + 64'd32768) >> 16;
                if (e > 64'd65535) begin
                    e = 64'd65535;
                end
                decay_lut[k] = e[FACTOR_W-1:0];
                p = (p * EXP_STEP) >> 32;
            end
            threshold    = 18'sd256;
            refractory   = '0;
            decay_rate   = 16'd6554;
            for (int c = 0; c < NUM_CH; c++) begin
                weight[c] = 16'sd256;
            end
            carry_time   = '0;
            carry_weight = '0;
            carry_valid  = 1'b0;
            has_fired    = 1'b0;
            last_fire    = '0;
            failures     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD:  threshold  = data[THRESH_W-1:0];
                REG_REFRACTORY: refractory = data[TIME_W-1:0];
                REG_DECAY_RATE: decay_rate = data[RATE_W-1:0];
                REG_WEIGHT_0:   weight[0]  = data[WEIGHT_W-1:0];
                REG_WEIGHT_1:   weight[1]  = data[WEIGHT_W-1:0];
                REG_WEIGHT_2:   weight[2]  = data[WEIGHT_W-1:0];
                REG_WEIGHT_3:   weight[3]  = data[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // exp(-dt/tau) in Q0.16, zero once the index runs off the table
        function logic [FACTOR_W-1:0] decay_factor(logic [TIME_W-1:0] dt);
            logic [63:0] idx;
            idx = (64'(dt) * 64'(decay_rate)) >> LUT_SHIFT;
            if (idx >= 64'(LUT_DEPTH)) begin
                return '0;
            end
            return decay_lut[idx];
        endfunction

        function void note_spike(logic [TIME_W-1:0] t, logic [CHANNEL_W-1:0] ch);
            longint pot;
            longint prod;
            if (int'(ch) >= NUM_CH) begin
                return;
            end
            // inside the refractory window: drop, state untouched
            if (has_fired && ((t - last_fire) <= refractory)) begin
                return;
            end
            pot = longint'(weight[ch]);
            if (carry_valid) begin
                prod = longint'(carry_weight) * longint'(decay_factor(t - carry_time));
                pot  = pot + (prod >>> 16);   // floor towards minus infinity
            end
            if (pot >= longint'(threshold)) begin
                has_fired   = 1'b1;
                last_fire   = t;
                carry_valid = 1'b0;
                expected_fires.push_back(t);
            end else begin
                carry_time   = t;
                carry_weight = weight[ch];
                carry_valid  = 1'b1;
            end
        endfunction

        function void check_fire(logic [TIME_W-1:0] actual);
            logic [TIME_W-1:0] want;
            if (expected_fires.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%0t: unexpected fire_time %h", $realtime, actual);
                end
                return;
            end
            want = expected_fires.pop_front();
            if (want !== actual) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%0t: fire_time expected %h, got %h", $realtime, want, actual);
                end
            end
        endfunction
    endclass

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [TIME_W-1:0]      s_spike_time = '0;
    logic [CHANNEL_W-1:0]   s_channel    = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [TIME_W-1:0]      m_fire_time;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    fire_scoreboard sb;
    bit             no_idle = 1'b0;
    logic [31:0]    cur_t   = '0;
    int             cycles  = 0;

    spike_coincidence_detector dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_spike_time (s_spike_time),
        .s_channel    (s_channel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fire_time  (m_fire_time),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one; none during a burst stretch.
    function automatic int next_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advance the spike clock: repeats, close pairs, decay-scaled steps, jumps,
    // backward steps and runs near the top of the time range.
    function automatic logic [31:0] next_time(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)      cur_t = cur_t;
        else if (r < 45) cur_t = cur_t + $urandom_range(1, 4);
        else if (r < 80) cur_t = cur_t + $urandom_range(0, span);
        else if (r < 90) cur_t = cur_t + $urandom;
        else if (r < 95) cur_t = cur_t - $urandom_range(1, 1000);
        else             cur_t = 32'hFFFF_FFFF - $urandom_range(0, 50);
        return cur_t;
    endfunction

    // Weight near the threshold so that lone spikes often stay below it.
    function automatic logic [31:0] near_weight(int thr);
        int          w;
        logic [31:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            w = -int'($urandom_range(0, 32768));
        end else begin
            w = thr * int'($urandom_range(40, 110)) / 100;
        end
        if (w > 32767)  w = 32767;
        if (w < -32768) w = -32768;
        return {junk[31:16], w[15:0]};
    endfunction

    function automatic logic [31:0] pick_edge(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 2))
            0:       return lo;
            1:       return hi;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_spike(input logic [TIME_W-1:0] t, input logic [CHANNEL_W-1:0] ch);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_spike_time <= t;
        s_channel    <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Write every register, the spare index too; only called while idle.
    task automatic load_config(input logic [31:0] thr, input logic [31:0] refr,
                               input logic [31:0] rate, input logic [31:0] w0,
                               input logic [31:0] w1, input logic [31:0] w2,
                               input logic [31:0] w3);
        cfg_write(REG_THRESHOLD, thr);
        cfg_write(REG_REFRACTORY, refr);
        cfg_write(REG_DECAY_RATE, rate);
        cfg_write(REG_WEIGHT_0, w0);
        cfg_write(REG_WEIGHT_1, w1);
        cfg_write(REG_WEIGHT_2, w2);
        cfg_write(REG_WEIGHT_3, w3);
        cfg_write(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every predicted fire has come out, then let any
    // non-firing spike still in the sequencer finish.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_fires.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: ready runs broken by stalls of random length.
    initial begin
        forever begin
            int g;
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            g = next_gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    // Sample every handshake at the clock edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.note_spike(s_spike_time, s_channel);
            end
            if (m_valid && m_ready) begin
                sb.check_fire(m_fire_time);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          mode;
        int          thr;
        int          span;
        logic [31:0] rate;
        logic [31:0] refr;
        logic [31:0] junk;

        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: every lone spike reaches threshold; repeat at the
        // fire time is refractory; a jump to the top and a wrap back to small times.
        send_spike(32'd0, 2'd0);
        send_spike(32'd0, 2'd1);
        send_spike(32'd5, 2'd3);
        send_spike(32'hFFFF_FFFF, 2'd2);
        send_spike(32'd3, 2'd1);
        drain();

        // Two spikes summing over threshold, refractory drop, backward time,
        // decay index past the end of the table.
        load_config(32'd400, 32'd10, 32'd6554, 32'd256, 32'd256, 32'd256, 32'd256);
        send_spike(32'd100, 2'd0);
        send_spike(32'd101, 2'd1);
        send_spike(32'd105, 2'd2);
        send_spike(32'd111, 2'd3);
        send_spike(32'd50, 2'd0);
        send_spike(32'd1000, 2'd1);
        drain();

        // Lowest threshold and weights, endless refractory window, no decay.
        load_config(32'hFFFE_0000, 32'hFFFF_FFFF, 32'd0,
                    32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_spike(32'd7, 2'd0);
        send_spike(32'd8, 2'd1);
        send_spike(32'd0, 2'd2);
        drain();

        // Highest threshold and weights, fastest decay: nothing can fire.
        load_config(32'h0001_FFFF, 32'd0, 32'd65535,
                    32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF);
        send_spike(32'd10, 2'd0);
        send_spike(32'd10, 2'd1);
        send_spike(32'd11, 2'd3);
        drain();

        // Negative carried weight: the decayed contribution rounds downwards.
        load_config(32'hFFFF_FF9C, 32'd0, 32'd0,
                    32'h0000_8000, 32'h0000_8000, 32'h0000_7FFF, 32'd256);
        send_spike(32'd20, 2'd0);
        send_spike(32'd25, 2'd1);
        send_spike(32'd30, 2'd2);
        send_spike(32'd31, 2'd3);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode    = $urandom_range(0, 3);
            no_idle = ((ph % 7) == 3);
            junk    = $urandom;
            case (mode)
                0, 1: begin
                    thr = $urandom_range(64, 4000);
                    if ($urandom_range(0, 7) == 0) thr = -thr;
                    case ($urandom_range(0, 4))
                        0:       rate = $urandom_range(0, 65535);
                        1:       rate = $urandom_range(1, 2000);
                        2:       rate = 32'd6554;
                        3:       rate = 32'd65535;
                        default: rate = 32'd0;
                    endcase
                    refr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100000)
                                                       : $urandom_range(0, 6);
                    load_config({junk[31:18], thr[17:0]}, refr, {junk[15:0], rate[15:0]},
                                near_weight(thr), near_weight(thr),
                                near_weight(thr), near_weight(thr));
                end
                2: begin
                    rate = $urandom;
                    load_config($urandom, $urandom_range(0, 20), rate,
                                $urandom, $urandom, $urandom, $urandom);
                end
                default: begin
                    rate = pick_edge(32'd0, 32'd65535);
                    load_config(pick_edge(32'h0002_0000, 32'h0001_FFFF),
                                pick_edge(32'd0, 32'hFFFF_FFFF), rate,
                                pick_edge(32'h0000_8000, 32'h0000_7FFF),
                                pick_edge(32'h0000_8000, 32'h0000_7FFF),
                                pick_edge(32'h0000_8000, 32'h0000_7FFF),
                                pick_edge(32'h0000_8000, 32'h0000_7FFF));
                end
            endcase
            // scale time steps so the decay index sweeps over the table
            span = (rate[15:0] == 16'd0) ? 2000 : (300 * 4096) / int'(rate[15:0]) + 1;
            repeat (SPIKES_PER_PHASE) begin
                send_spike(next_time(span), 2'($urandom_range(0, NUM_CH - 1)));
            end
            drain();
        end
        no_idle = 1'b0;

        if (sb.failures == 0 && sb.expected_fires.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
